FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// depends on a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define QFT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// implication in the next cycle
`define QFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

FILE: sv/qft_pkg.sv
// shared widths, codes and types of the quaternion frame transform
// no dependencies
package qft_pkg;

	localparam int COORD_BITS = 32;
	localparam int QUAT_BITS  = 16;

	// quaternion products, norm and scaled rotation matrix
	localparam int PROD_W = 2 * QUAT_BITS;
	localparam int NORM_W = 2 * QUAT_BITS + 1;
	localparam int MAT_W  = 2 * QUAT_BITS + 2;
	// point vector after offset and remap
	localparam int VEC_W  = COORD_BITS + 2;
	// matrix times vector
	localparam int MV_W   = MAT_W + VEC_W;
	localparam int SUM_W  = MV_W + 2;
	// quotient magnitude bits, one divider stage each
	localparam int QUO_W  = COORD_BITS + 2;
	localparam int RND_W  = QUO_W + 1;
	localparam int RES_W  = QUO_W + 2;
	localparam int FIN_W  = RES_W + 1;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

	// direction commands
	localparam logic CMD_CAM_TO_WORLD = 1'b0;
	localparam logic CMD_WORLD_TO_CAM = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [QUAT_BITS-1:0]  quat_t;

	// one classified request as it waits for the back end
	typedef struct packed {
		logic                       cmd;
		logic                       zero;
		logic [NORM_W-1:0]          norm;
		logic [8:0][MAT_W-1:0]      mat;
		logic [2:0][VEC_W-1:0]      vec;
	} work_t;

endpackage

FILE: sv/qft_front.sv
// front end: accepts requests, forms quaternion products, matrix, norm and vector
// depends on qft_pkg
module qft_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  qft_pkg::quat_t      quat_w,
	input  qft_pkg::quat_t      quat_x,
	input  qft_pkg::quat_t      quat_y,
	input  qft_pkg::quat_t      quat_z,
	input  qft_pkg::coord_t     point_x,
	input  qft_pkg::coord_t     point_y,
	input  qft_pkg::coord_t     point_z,
	input  qft_pkg::coord_t     offset_x,
	input  qft_pkg::coord_t     offset_y,
	input  qft_pkg::coord_t     offset_z,
	output logic                push_valid,
	output qft_pkg::work_t      push_data,
	input  logic                queue_full
);

	logic adv;

	logic                                  v_s1;
	logic                                  cmd_s1;
	logic signed [qft_pkg::PROD_W-1:0]     ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [qft_pkg::PROD_W-1:0]     xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [qft_pkg::VEC_W-1:0]      vec_s1 [3];

	logic                v_s2;
	qft_pkg::work_t      work_s2;

	logic signed [qft_pkg::VEC_W-1:0]      vec_in [3];
	logic signed [qft_pkg::COORD_BITS:0]   sum_x, sum_y, sum_z;

	logic signed [qft_pkg::MAT_W-1:0]      e_ww, e_xx, e_yy, e_zz;
	logic signed [qft_pkg::MAT_W-1:0]      e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
	logic signed [qft_pkg::MAT_W-1:0]      nsum;
	qft_pkg::work_t                        work_d;

	// front advances unless a finished request cannot enter the queue
	assign adv        = !v_s2 || !queue_full;
	assign in_ready   = adv;
	assign push_valid = v_s2;
	assign push_data  = work_s2;

	// offset and axis remap for camera to world, plain point otherwise
	always_comb begin
		sum_x = (qft_pkg::COORD_BITS+1)'(point_x) + (qft_pkg::COORD_BITS+1)'(offset_x);
		sum_y = (qft_pkg::COORD_BITS+1)'(point_y) + (qft_pkg::COORD_BITS+1)'(offset_y);
		sum_z = (qft_pkg::COORD_BITS+1)'(point_z) + (qft_pkg::COORD_BITS+1)'(offset_z);
		if (command == qft_pkg::CMD_CAM_TO_WORLD) begin
			vec_in[0] = qft_pkg::VEC_W'(sum_z);
			vec_in[1] = -qft_pkg::VEC_W'(sum_x);
			vec_in[2] = -qft_pkg::VEC_W'(sum_y);
		end else begin
			vec_in[0] = qft_pkg::VEC_W'(point_x);
			vec_in[1] = qft_pkg::VEC_W'(point_y);
			vec_in[2] = qft_pkg::VEC_W'(point_z);
		end
	end

	// stage 1: quaternion products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			cmd_s1 <= command;
			ww_s1  <= quat_w * quat_w;
			xx_s1  <= quat_x * quat_x;
			yy_s1  <= quat_y * quat_y;
			zz_s1  <= quat_z * quat_z;
			xy_s1  <= quat_x * quat_y;
			xz_s1  <= quat_x * quat_z;
			yz_s1  <= quat_y * quat_z;
			wx_s1  <= quat_w * quat_x;
			wy_s1  <= quat_w * quat_y;
			wz_s1  <= quat_w * quat_z;
			for (int i = 0; i < 3; i++) begin
				vec_s1[i] <= vec_in[i];
			end
		end
	end

	// matrix scaled by the norm, and the norm itself
	always_comb begin
		e_ww = qft_pkg::MAT_W'(ww_s1);
		e_xx = qft_pkg::MAT_W'(xx_s1);
		e_yy = qft_pkg::MAT_W'(yy_s1);
		e_zz = qft_pkg::MAT_W'(zz_s1);
		e_xy = qft_pkg::MAT_W'(xy_s1);
		e_xz = qft_pkg::MAT_W'(xz_s1);
		e_yz = qft_pkg::MAT_W'(yz_s1);
		e_wx = qft_pkg::MAT_W'(wx_s1);
		e_wy = qft_pkg::MAT_W'(wy_s1);
		e_wz = qft_pkg::MAT_W'(wz_s1);
		nsum = e_ww + e_xx + e_yy + e_zz;
		work_d.cmd    = cmd_s1;
		work_d.norm   = nsum[qft_pkg::NORM_W-1:0];
		work_d.zero   = (nsum == '0);
		work_d.mat[0] = (e_ww + e_xx) - (e_yy + e_zz);
		work_d.mat[1] = (e_xy - e_wz) <<< 1;
		work_d.mat[2] = (e_xz + e_wy) <<< 1;
		work_d.mat[3] = (e_xy + e_wz) <<< 1;
		work_d.mat[4] = (e_ww + e_yy) - (e_xx + e_zz);
		work_d.mat[5] = (e_yz - e_wx) <<< 1;
		work_d.mat[6] = (e_xz - e_wy) <<< 1;
		work_d.mat[7] = (e_yz + e_wx) <<< 1;
		work_d.mat[8] = (e_ww + e_zz) - (e_xx + e_yy);
		for (int i = 0; i < 3; i++) begin
			work_d.vec[i] = vec_s1[i];
		end
	end

	// stage 2: classified request ready for the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			work_s2 <= work_d;
		end
	end

endmodule

FILE: sv/qft_queue.sv
// short queue between front and back ends
// depends on qft_pkg
module qft_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  qft_pkg::work_t  push_data,
	output logic            full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output qft_pkg::work_t  pop_data
);

	qft_pkg::work_t                 entry_q [qft_pkg::QDEPTH];
	logic [qft_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [qft_pkg::QPTR_W:0]       count_q;
	logic                           do_push, do_pop;

	assign full      = (count_q == (qft_pkg::QPTR_W+1)'(qft_pkg::QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/qft_back.sv
// back end: matrix times vector, pipelined rounding divide, offset and saturation
// depends on qft_pkg
module qft_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  qft_pkg::work_t  pop_data,
	input  qft_pkg::coord_t offset_x,
	input  qft_pkg::coord_t offset_y,
	input  qft_pkg::coord_t offset_z,
	output logic            out_valid,
	input  logic            out_ready,
	output qft_pkg::coord_t out_x,
	output qft_pkg::coord_t out_y,
	output qft_pkg::coord_t out_z,
	output logic            zero_quaternion,
	output logic            clipped
);

	localparam int NW = qft_pkg::NORM_W;
	localparam int QW = qft_pkg::QUO_W;

	logic adv;

	// stage 1: nine products
	logic                                v_s1, cmd_s1, zero_s1;
	logic [NW-1:0]                       norm_s1;
	logic signed [qft_pkg::MV_W-1:0]     prod_s1 [9];

	// stage 2: three sums
	logic                                v_s2, cmd_s2, zero_s2;
	logic [NW-1:0]                       norm_s2;
	logic signed [qft_pkg::SUM_W-1:0]    sum_s2 [3];

	// divider stages, one quotient bit each
	logic                                dv_v_s    [QW+1];
	logic                                dv_cmd_s  [QW+1];
	logic                                dv_zero_s [QW+1];
	logic [NW-1:0]                       dv_norm_s [QW+1];
	logic [2:0]                          dv_neg_s  [QW+1];
	logic [NW-1:0]                       dv_rem_s  [QW+1][3];
	logic [QW-1:0]                       dv_mq_s   [QW+1][3];

	// rounded, signed quotients
	logic                                v_s4, cmd_s4, zero_s4;
	logic signed [qft_pkg::RES_W-1:0]    quo_s4 [3];

	// output register
	logic                                v_s5, zero_s5, clip_s5;
	qft_pkg::coord_t                     res_s5 [3];

	logic signed [qft_pkg::MAT_W-1:0]    m_sel [9];
	logic [qft_pkg::SUM_W-1:0]           mag [3];
	logic [qft_pkg::RES_W-1:0]           quo_d [3];
	logic [qft_pkg::RND_W-1:0]           rnd [3];
	logic                                up [3];
	logic signed [qft_pkg::FIN_W-1:0]    fin [3];
	qft_pkg::coord_t                     res_d [3];
	logic                                clip_d;

	// the whole back end moves while the output register can take a result
	assign adv       = !v_s5 || out_ready;
	assign pop_ready = adv;

	// camera to world uses M, world to camera its transpose
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (pop_data.cmd == qft_pkg::CMD_CAM_TO_WORLD) begin
					m_sel[i*3+j] = $signed(pop_data.mat[i*3+j]);
				end else begin
					m_sel[i*3+j] = $signed(pop_data.mat[j*3+i]);
				end
			end
		end
	end

	// stages 1 and 2 and divider entry: valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dv_v_s[0]   <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop_valid;
			v_s2        <= v_s1;
			dv_v_s[0]   <= v_s2;
		end
	end

	// magnitude of each sum for the divider
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = sum_s2[i][qft_pkg::SUM_W-1] ? qft_pkg::SUM_W'(-sum_s2[i])
				: qft_pkg::SUM_W'(sum_s2[i]);
		end
	end

	// products, sums and divider entry
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= pop_data.cmd;
			zero_s1 <= pop_data.zero;
			norm_s1 <= pop_data.norm;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i*3+j] <= m_sel[i*3+j] * $signed(pop_data.vec[j]);
				end
			end
			cmd_s2  <= cmd_s1;
			zero_s2 <= zero_s1;
			norm_s2 <= norm_s1;
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= qft_pkg::SUM_W'(prod_s1[i*3])
					+ qft_pkg::SUM_W'(prod_s1[i*3+1])
					+ qft_pkg::SUM_W'(prod_s1[i*3+2]);
			end
			dv_cmd_s[0]  <= cmd_s2;
			dv_zero_s[0] <= zero_s2;
			dv_norm_s[0] <= norm_s2;
			for (int i = 0; i < 3; i++) begin
				dv_neg_s[0][i] <= sum_s2[i][qft_pkg::SUM_W-1];
				dv_rem_s[0][i] <= mag[i][NW+QW-1:QW];
				dv_mq_s[0][i]  <= mag[i][QW-1:0];
			end
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k <= QW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_cmd_s[k]  <= dv_cmd_s[k-1];
				dv_zero_s[k] <= dv_zero_s[k-1];
				dv_norm_s[k] <= dv_norm_s[k-1];
				dv_neg_s[k]  <= dv_neg_s[k-1];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [NW:0] trial;
			logic [NW:0] diff;
			logic        ge;

			assign trial = {dv_rem_s[k-1][i], dv_mq_s[k-1][i][QW-1]};
			assign diff  = trial - {1'b0, dv_norm_s[k-1]};
			assign ge    = (trial >= {1'b0, dv_norm_s[k-1]});

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k][i] <= ge ? diff[NW-1:0] : trial[NW-1:0];
					dv_mq_s[k][i]  <= {dv_mq_s[k-1][i][QW-2:0], ge};
				end
			end
		end
	end

	// round half away from zero, then restore the sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			up[i]    = ({dv_rem_s[QW][i], 1'b0} >= {1'b0, dv_norm_s[QW]});
			rnd[i]   = qft_pkg::RND_W'(dv_mq_s[QW][i]) + qft_pkg::RND_W'(up[i]);
			quo_d[i] = dv_neg_s[QW][i] ? -qft_pkg::RES_W'(rnd[i]) : qft_pkg::RES_W'(rnd[i]);
		end
	end

	// stage 4 and output register: valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s4 <= dv_v_s[QW];
			v_s5 <= v_s4;
		end
	end

	// remap and offset for world to camera, then saturate; a zero quaternion gives zero
	always_comb begin
		if (cmd_s4 == qft_pkg::CMD_CAM_TO_WORLD) begin
			for (int i = 0; i < 3; i++) begin
				fin[i] = qft_pkg::FIN_W'(quo_s4[i]);
			end
		end else begin
			fin[0] = -qft_pkg::FIN_W'(quo_s4[1]) - qft_pkg::FIN_W'(offset_x);
			fin[1] = -qft_pkg::FIN_W'(quo_s4[2]) - qft_pkg::FIN_W'(offset_y);
			fin[2] = qft_pkg::FIN_W'(quo_s4[0]) - qft_pkg::FIN_W'(offset_z);
		end
		clip_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (fin[i][qft_pkg::FIN_W-1:qft_pkg::COORD_BITS-1] == '0 ||
				fin[i][qft_pkg::FIN_W-1:qft_pkg::COORD_BITS-1] == '1) begin
				res_d[i] = fin[i][qft_pkg::COORD_BITS-1:0];
			end else begin
				clip_d   = 1'b1;
				res_d[i] = {fin[i][qft_pkg::FIN_W-1],
					{(qft_pkg::COORD_BITS-1){!fin[i][qft_pkg::FIN_W-1]}}};
			end
		end
		if (zero_s4) begin
			clip_d = 1'b0;
			for (int i = 0; i < 3; i++) begin
				res_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4  <= dv_cmd_s[QW];
			zero_s4 <= dv_zero_s[QW];
			for (int i = 0; i < 3; i++) begin
				quo_s4[i] <= $signed(quo_d[i]);
			end
			zero_s5 <= zero_s4;
			clip_s5 <= clip_d;
			for (int i = 0; i < 3; i++) begin
				res_s5[i] <= res_d[i];
			end
		end
	end

	assign out_valid       = v_s5;
	assign out_x           = res_s5[0];
	assign out_y           = res_s5[1];
	assign out_z           = res_s5[2];
	assign zero_quaternion = zero_s5;
	assign clipped         = clip_s5;

endmodule

FILE: sv/quaternion_frame_transform_unit.sv
// top level of the quaternion frame transform: offset registers, front, queue, back
// depends on qft_pkg, qft_front, qft_queue, qft_back
//
// channel   signals                                     direction
// in        in_valid/in_ready, command, quat_*, point_*   into block
// out       out_valid/out_ready, out_*, flags             out of block
// cfg       cfg_we, cfg_index, cfg_data                   into block, write only
//
// one request per cycle sustained while the output is not stalled; out_valid rises
// once an accepted request has passed the front stages, the queue, five back stages
// and the 34-stage rounding divider.
// reset clears the offsets, the queue and all valid flags.
// a stall at the output holds the back end; the front keeps taking requests
// until the four-entry queue fills, then in_ready drops.
module quaternion_frame_transform_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qft_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  qft_pkg::coord_t                   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  qft_pkg::quat_t                    quat_w,
	input  qft_pkg::quat_t                    quat_x,
	input  qft_pkg::quat_t                    quat_y,
	input  qft_pkg::quat_t                    quat_z,
	input  qft_pkg::coord_t                   point_x,
	input  qft_pkg::coord_t                   point_y,
	input  qft_pkg::coord_t                   point_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output qft_pkg::coord_t                   out_x,
	output qft_pkg::coord_t                   out_y,
	output qft_pkg::coord_t                   out_z,
	output logic                              zero_quaternion,
	output logic                              clipped
);

	qft_pkg::coord_t offset_x_q, offset_y_q, offset_z_q;
	logic            push_valid, queue_full, pop_valid, pop_ready;
	qft_pkg::work_t  push_data, pop_data;

	// offset registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qft_pkg::REG_OFFSET_X: offset_x_q <= cfg_data;
				qft_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data;
				qft_pkg::REG_OFFSET_Z: offset_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	qft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.quat_w     (quat_w),
		.quat_x     (quat_x),
		.quat_y     (quat_y),
		.quat_z     (quat_z),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.offset_x   (offset_x_q),
		.offset_y   (offset_y_q),
		.offset_z   (offset_z_q),
		.push_valid (push_valid),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	qft_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	qft_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_data        (pop_data),
		.offset_x        (offset_x_q),
		.offset_y        (offset_y_q),
		.offset_z        (offset_z_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.zero_quaternion (zero_quaternion),
		.clipped         (clipped)
	);

endmodule

FILE: sv/qft_checker.sv
// port-level checks of the quaternion frame transform, bound to the top level
// depends on qft_pkg and assert_macros.svh
`include "assert_macros.svh"

module qft_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  qft_pkg::coord_t                   out_x,
	input  qft_pkg::coord_t                   out_y,
	input  qft_pkg::coord_t                   out_z,
	input  logic                              zero_quaternion,
	input  logic                              clipped
);

	localparam qft_pkg::coord_t CMAX = {1'b0, {(qft_pkg::COORD_BITS-1){1'b1}}};
	localparam qft_pkg::coord_t CMIN = {1'b1, {(qft_pkg::COORD_BITS-1){1'b0}}};

	logic any_rail;
	assign any_rail = (out_x == CMAX) || (out_x == CMIN) || (out_y == CMAX) ||
		(out_y == CMIN) || (out_z == CMAX) || (out_z == CMIN);

	// a held result stays put
	`QFT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(clipped))

	// a zero quaternion gives a zero point and no clipping
	`QFT_ASSERT_SAME(a_zero_result, out_valid && zero_quaternion,
		out_x == '0 && out_y == '0 && out_z == '0 && !clipped)

	// clipping leaves at least one component on a rail
	`QFT_ASSERT_SAME(a_clip_rail, out_valid && clipped, any_rail)

endmodule

bind quaternion_frame_transform_unit qft_checker u_qft_checker (.*);
